[src/qau_pkg.sv]
// ----------------------------------------------------------------------------
// qau_pkg
// shared opcode type and field widths for the quaternion arithmetic unit
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int FUNC_W   = 3;
  localparam int NUM_COMP = 4;   // x, y, z, w
  localparam int NUM_TERM = 4;   // products summed per result value

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD   = 3'd0,
    FUNC_SUB   = 3'd1,
    FUNC_PROD  = 3'd2,
    FUNC_CONJ  = 3'd3,
    FUNC_NEG   = 3'd4,
    FUNC_SCALE = 3'd5,
    FUNC_DOT   = 3'd6,
    FUNC_LERP  = 3'd7
  } func_t;

  // component index
  localparam int CX = 0;
  localparam int CY = 1;
  localparam int CZ = 2;
  localparam int CW = 3;

endpackage

[src/qau_if.sv]
// ----------------------------------------------------------------------------
// qau interfaces
// valid/ready channels for operand words and result words
// ----------------------------------------------------------------------------
interface qau_in_if #(
  parameter int COMPONENT_WIDTH = 16
);
  logic                               valid;
  logic                               ready;
  logic [qau_pkg::FUNC_W-1:0]         func;
  logic signed [COMPONENT_WIDTH-1:0]  a_x;
  logic signed [COMPONENT_WIDTH-1:0]  a_y;
  logic signed [COMPONENT_WIDTH-1:0]  a_z;
  logic signed [COMPONENT_WIDTH-1:0]  a_w;
  logic signed [COMPONENT_WIDTH-1:0]  b_x;
  logic signed [COMPONENT_WIDTH-1:0]  b_y;
  logic signed [COMPONENT_WIDTH-1:0]  b_z;
  logic signed [COMPONENT_WIDTH-1:0]  b_w;
  logic signed [COMPONENT_WIDTH-1:0]  scalar_in;

  modport source (
    output valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in,
    input  ready
  );
  modport sink (
    input  valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in,
    output ready
  );
endinterface

interface qau_out_if #(
  parameter int COMPONENT_WIDTH = 16
);
  logic                               valid;
  logic                               ready;
  logic signed [COMPONENT_WIDTH-1:0]  r_x;
  logic signed [COMPONENT_WIDTH-1:0]  r_y;
  logic signed [COMPONENT_WIDTH-1:0]  r_z;
  logic signed [COMPONENT_WIDTH-1:0]  r_w;
  logic signed [COMPONENT_WIDTH-1:0]  scalar_out;
  logic                               saturated;

  modport source (
    output valid, r_x, r_y, r_z, r_w, scalar_out, saturated,
    input  ready
  );
  modport sink (
    input  valid, r_x, r_y, r_z, r_w, scalar_out, saturated,
    output ready
  );
endinterface

[src/quaternion_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// fixed-point quaternion alu: add, sub, hamilton product, conjugate, negate,
// scale, dot and lerp with round-half-up and saturation
// ----------------------------------------------------------------------------
// an accepted input word passes the operand register, then the result register, to out_port
// throughput: one word per cycle while out_port keeps taking words; the operand register and the result register
//   each advance whenever the stage after them is empty or being drained
// reset: synchronous active-low rst_n clears both stage valid flags only;
//   operand and result data registers are not reset
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRACTION_BITS   = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  qau_in_if.sink              in_port,
  qau_out_if.source           out_port
);

  localparam int NC    = qau_pkg::NUM_COMP;
  localparam int NT    = qau_pkg::NUM_TERM;
  // operand width: one extra bit holds b - a and the negation of the minimum
  localparam int OP_W  = COMPONENT_WIDTH + 1;
  localparam int PRD_W = 2 * OP_W;
  // accumulator: four products plus headroom, and room for the rounding constant
  localparam int ACC_W = (PRD_W + 2 > FRACTION_BITS + 2) ? PRD_W + 2 : FRACTION_BITS + 2;
  localparam int BAS_W = COMPONENT_WIDTH + 2;
  localparam int TOT_W = ACC_W + 1;

  localparam logic signed [ACC_W-1:0] RND_HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (FRACTION_BITS - 1);
  localparam logic signed [TOT_W-1:0] VAL_MAX =
    {{(TOT_W-COMPONENT_WIDTH+1){1'b0}}, {(COMPONENT_WIDTH-1){1'b1}}};
  localparam logic signed [TOT_W-1:0] VAL_MIN =
    {{(TOT_W-COMPONENT_WIDTH+1){1'b1}}, {(COMPONENT_WIDTH-1){1'b0}}};

  // --------------------------------------------------------------------------
  // stage handshake: operand register (s1) then result register (s2)
  // --------------------------------------------------------------------------
  logic s1_valid_r;
  logic s2_valid_r;
  logic s2_load;
  logic s1_load;

  assign s2_load = !s2_valid_r || out_port.ready;           // result register free
  assign s1_load = !s1_valid_r || s2_load;                  // operand register free
  assign in_port.ready = s1_load;

  // --------------------------------------------------------------------------
  // operand register
  // --------------------------------------------------------------------------
  qau_pkg::func_t                    func_r;
  logic signed [COMPONENT_WIDTH-1:0] a_r [NC];
  logic signed [COMPONENT_WIDTH-1:0] b_r [NC];
  logic signed [COMPONENT_WIDTH-1:0] s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_port.valid;
    end
    if (s1_load && in_port.valid) begin
      func_r           <= qau_pkg::func_t'(in_port.func);
      a_r[qau_pkg::CX] <= in_port.a_x;
      a_r[qau_pkg::CY] <= in_port.a_y;
      a_r[qau_pkg::CZ] <= in_port.a_z;
      a_r[qau_pkg::CW] <= in_port.a_w;
      b_r[qau_pkg::CX] <= in_port.b_x;
      b_r[qau_pkg::CY] <= in_port.b_y;
      b_r[qau_pkg::CZ] <= in_port.b_z;
      b_r[qau_pkg::CW] <= in_port.b_w;
      s_r              <= in_port.scalar_in;
    end
  end

  // --------------------------------------------------------------------------
  // operand steering
  // every lane computes base + round(sum of four products); add, sub,
  // conjugate and negate are exact so they use only the base term, while
  // lerp uses a as base plus round((b - a) * s). the dot product runs in
  // lane w and is routed to scalar_out
  // --------------------------------------------------------------------------
  logic signed [OP_W-1:0]  ae [NC];
  logic signed [OP_W-1:0]  be [NC];
  logic signed [OP_W-1:0]  nb [NC];
  logic signed [OP_W-1:0]  de [NC];
  logic signed [OP_W-1:0]  se;
  logic signed [OP_W-1:0]  pa [NC][NT];
  logic signed [OP_W-1:0]  pb [NC][NT];
  logic signed [BAS_W-1:0] base [NC];

  always_comb begin
    se = OP_W'(s_r);
    for (int i = 0; i < NC; i++) begin
      ae[i]   = OP_W'(a_r[i]);
      be[i]   = OP_W'(b_r[i]);
      nb[i]   = -be[i];
      de[i]   = be[i] - ae[i];
      base[i] = '0;
      for (int k = 0; k < NT; k++) begin
        pa[i][k] = '0;
        pb[i][k] = '0;
      end
    end

    case (func_r)
      qau_pkg::FUNC_ADD: begin
        for (int i = 0; i < NC; i++) base[i] = BAS_W'(ae[i]) + BAS_W'(be[i]);
      end
      qau_pkg::FUNC_SUB: begin
        for (int i = 0; i < NC; i++) base[i] = BAS_W'(ae[i]) - BAS_W'(be[i]);
      end
      qau_pkg::FUNC_PROD: begin
        // x = bx*aw + ax*bw + by*az - bz*ay
        pa[qau_pkg::CX][0] = be[qau_pkg::CX]; pb[qau_pkg::CX][0] = ae[qau_pkg::CW];
        pa[qau_pkg::CX][1] = ae[qau_pkg::CX]; pb[qau_pkg::CX][1] = be[qau_pkg::CW];
        pa[qau_pkg::CX][2] = be[qau_pkg::CY]; pb[qau_pkg::CX][2] = ae[qau_pkg::CZ];
        pa[qau_pkg::CX][3] = nb[qau_pkg::CZ]; pb[qau_pkg::CX][3] = ae[qau_pkg::CY];
        // y = by*aw + ay*bw + bz*ax - bx*az
        pa[qau_pkg::CY][0] = be[qau_pkg::CY]; pb[qau_pkg::CY][0] = ae[qau_pkg::CW];
        pa[qau_pkg::CY][1] = ae[qau_pkg::CY]; pb[qau_pkg::CY][1] = be[qau_pkg::CW];
        pa[qau_pkg::CY][2] = be[qau_pkg::CZ]; pb[qau_pkg::CY][2] = ae[qau_pkg::CX];
        pa[qau_pkg::CY][3] = nb[qau_pkg::CX]; pb[qau_pkg::CY][3] = ae[qau_pkg::CZ];
        // z = bz*aw + az*bw + bx*ay - by*ax
        pa[qau_pkg::CZ][0] = be[qau_pkg::CZ]; pb[qau_pkg::CZ][0] = ae[qau_pkg::CW];
        pa[qau_pkg::CZ][1] = ae[qau_pkg::CZ]; pb[qau_pkg::CZ][1] = be[qau_pkg::CW];
        pa[qau_pkg::CZ][2] = be[qau_pkg::CX]; pb[qau_pkg::CZ][2] = ae[qau_pkg::CY];
        pa[qau_pkg::CZ][3] = nb[qau_pkg::CY]; pb[qau_pkg::CZ][3] = ae[qau_pkg::CX];
        // w = bw*aw - bx*ax - by*ay - bz*az
        pa[qau_pkg::CW][0] = be[qau_pkg::CW]; pb[qau_pkg::CW][0] = ae[qau_pkg::CW];
        pa[qau_pkg::CW][1] = nb[qau_pkg::CX]; pb[qau_pkg::CW][1] = ae[qau_pkg::CX];
        pa[qau_pkg::CW][2] = nb[qau_pkg::CY]; pb[qau_pkg::CW][2] = ae[qau_pkg::CY];
        pa[qau_pkg::CW][3] = nb[qau_pkg::CZ]; pb[qau_pkg::CW][3] = ae[qau_pkg::CZ];
      end
      qau_pkg::FUNC_CONJ: begin
        for (int i = 0; i < NC; i++) base[i] = -BAS_W'(ae[i]);
        base[qau_pkg::CW] = BAS_W'(ae[qau_pkg::CW]);
      end
      qau_pkg::FUNC_NEG: begin
        for (int i = 0; i < NC; i++) base[i] = -BAS_W'(ae[i]);
      end
      qau_pkg::FUNC_SCALE: begin
        for (int i = 0; i < NC; i++) begin
          pa[i][0] = ae[i];
          pb[i][0] = se;
        end
      end
      qau_pkg::FUNC_DOT: begin
        for (int k = 0; k < NT; k++) begin
          pa[qau_pkg::CW][k] = ae[k];
          pb[qau_pkg::CW][k] = be[k];
        end
      end
      qau_pkg::FUNC_LERP: begin
        for (int i = 0; i < NC; i++) begin
          base[i]  = BAS_W'(ae[i]);
          pa[i][0] = de[i];
          pb[i][0] = se;
        end
      end
      default: begin
        for (int i = 0; i < NC; i++) base[i] = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // products, exact sum, round half up, add base, saturate
  // --------------------------------------------------------------------------
  logic signed [PRD_W-1:0] prod [NC][NT];
  logic signed [ACC_W-1:0] acc  [NC];
  logic signed [ACC_W-1:0] rnd  [NC];
  logic signed [TOT_W-1:0] tot  [NC];
  logic signed [COMPONENT_WIDTH-1:0] lane [NC];
  logic [NC-1:0] lane_sat;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      acc[i] = '0;
      for (int k = 0; k < NT; k++) begin
        prod[i][k] = pa[i][k] * pb[i][k];
        acc[i]     = acc[i] + ACC_W'(prod[i][k]);
      end
      rnd[i] = (acc[i] + RND_HALF) >>> FRACTION_BITS;
      tot[i] = TOT_W'(rnd[i]) + TOT_W'(base[i]);
      if (tot[i] > VAL_MAX) begin
        lane[i]     = VAL_MAX[COMPONENT_WIDTH-1:0];
        lane_sat[i] = 1'b1;
      end else if (tot[i] < VAL_MIN) begin
        lane[i]     = VAL_MIN[COMPONENT_WIDTH-1:0];
        lane_sat[i] = 1'b1;
      end else begin
        lane[i]     = tot[i][COMPONENT_WIDTH-1:0];
        lane_sat[i] = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  logic signed [COMPONENT_WIDTH-1:0] r_r [NC];
  logic signed [COMPONENT_WIDTH-1:0] so_r;
  logic                              sat_r;
  logic                              is_dot;

  assign is_dot = (func_r == qau_pkg::FUNC_DOT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load) begin
      s2_valid_r <= s1_valid_r;
    end
    if (s2_load && s1_valid_r) begin
      r_r[qau_pkg::CX] <= lane[qau_pkg::CX];
      r_r[qau_pkg::CY] <= lane[qau_pkg::CY];
      r_r[qau_pkg::CZ] <= lane[qau_pkg::CZ];
      // lane w carries the dot product when func is dot
      r_r[qau_pkg::CW] <= is_dot ? '0 : lane[qau_pkg::CW];
      so_r             <= is_dot ? lane[qau_pkg::CW] : '0;
      sat_r            <= |lane_sat;
    end
  end

  assign out_port.valid      = s2_valid_r;
  assign out_port.r_x        = r_r[qau_pkg::CX];
  assign out_port.r_y        = r_r[qau_pkg::CY];
  assign out_port.r_z        = r_r[qau_pkg::CZ];
  assign out_port.r_w        = r_r[qau_pkg::CW];
  assign out_port.scalar_out = so_r;
  assign out_port.saturated  = sat_r;

endmodule

[src/qau_checker.sv]
// ----------------------------------------------------------------------------
// qau_checker
// port-level checks for the quaternion arithmetic unit
// ----------------------------------------------------------------------------
module qau_checker #(
  parameter int COMPONENT_WIDTH = 16
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [COMPONENT_WIDTH-1:0] r_x,
  input logic signed [COMPONENT_WIDTH-1:0] r_y,
  input logic signed [COMPONENT_WIDTH-1:0] r_z,
  input logic signed [COMPONENT_WIDTH-1:0] r_w,
  input logic signed [COMPONENT_WIDTH-1:0] scalar_out,
  input logic                              saturated
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(r_x) && $stable(r_y) &&
      $stable(r_z) && $stable(r_w) && $stable(scalar_out) && $stable(saturated))
    else $error("result word changed while stalled");

  // each accepted word goes through the operand and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("no result word two cycles after accept");

  // with the result register empty the unit must take input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

  // dot output excludes the quaternion fields
  a_dot_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (scalar_out != '0) |-> (r_x == '0) && (r_y == '0) &&
      (r_z == '0) && (r_w == '0))
    else $error("scalar and quaternion result both nonzero");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind quaternion_arithmetic_unit qau_checker #(
  .COMPONENT_WIDTH (COMPONENT_WIDTH)
) u_qau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_port.valid),
  .in_ready   (in_port.ready),
  .out_valid  (out_port.valid),
  .out_ready  (out_port.ready),
  .r_x        (out_port.r_x),
  .r_y        (out_port.r_y),
  .r_z        (out_port.r_z),
  .r_w        (out_port.r_w),
  .scalar_out (out_port.scalar_out),
  .saturated  (out_port.saturated)
);

[bench/quaternion_arithmetic_unit_tb.sv]
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_tb
// self-checking bench for the quaternion alu: every operand word sent is run
// through a local fixed-point model, and each result word is checked field by
// field, in order, against the model; directed corner cases come first, then
// random words under three idling patterns on the two channels
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_tb;

  localparam int COMP_W    = 16;
  localparam int FRAC_BITS = 12;

  // rounding and clipping bounds, kept wide so sums never wrap
  localparam longint Q_UNIT = longint'(1) << FRAC_BITS;
  localparam longint Q_HALF = longint'(1) << (FRAC_BITS - 1);
  localparam longint V_MAX  = (longint'(1) << (COMP_W - 1)) - 1;
  localparam longint V_MIN  = -V_MAX - 1;

  typedef logic signed [COMP_W-1:0] comp_t;

  localparam int Q_ONE  = int'(Q_UNIT);
  localparam int Q_MONE = int'(-Q_UNIT);
  localparam int Q_MAX  = int'(V_MAX);
  localparam int Q_MIN  = int'(V_MIN);

  // one operand word and one result word
  typedef struct packed {
    qau_pkg::func_t func;
    comp_t ax, ay, az, aw;
    comp_t bx, by, bz, bw;
    comp_t s;
  } operand_t;

  typedef struct packed {
    comp_t rx, ry, rz, rw;
    comp_t so;
    logic  sat;
  } result_t;

  logic clk;
  logic rst_n;

  qau_in_if  #(.COMPONENT_WIDTH(COMP_W)) in_if  ();
  qau_out_if #(.COMPONENT_WIDTH(COMP_W)) out_if ();

  quaternion_arithmetic_unit #(
    .COMPONENT_WIDTH(COMP_W),
    .FRACTION_BITS  (FRAC_BITS)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_port (in_if),
    .out_port(out_if)
  );

  // results still owed by the unit, oldest first
  result_t     pending_results[$];
  int          err_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // fixed-point model of the alu
  // each produced value is an exact sum of products, rounded half up at the
  // fraction point and clipped to the component range; values that an
  // opcode does not produce stay zero and so can never clip
  // ------------------------------------------------------------------------
  function automatic result_t quat_alu_result(operand_t op);
    longint  a[4];
    longint  b[4];
    longint  acc[5];
    longint  s;
    longint  v;
    comp_t   r[5];
    logic    clipped;
    result_t res;
    a[0] = longint'(op.ax); a[1] = longint'(op.ay);
    a[2] = longint'(op.az); a[3] = longint'(op.aw);
    b[0] = longint'(op.bx); b[1] = longint'(op.by);
    b[2] = longint'(op.bz); b[3] = longint'(op.bw);
    s = longint'(op.s);
    clipped = 1'b0;
    for (int i = 0; i < 5; i++) acc[i] = 0;
    case (op.func)
      qau_pkg::FUNC_ADD: begin
        for (int i = 0; i < 4; i++) acc[i] = (a[i] + b[i]) * Q_UNIT;
      end
      qau_pkg::FUNC_SUB: begin
        for (int i = 0; i < 4; i++) acc[i] = (a[i] - b[i]) * Q_UNIT;
      end
      qau_pkg::FUNC_PROD: begin
        // hamilton product, b then a, index 3 is the scalar part
        acc[0] = b[0]*a[3] + a[0]*b[3] + b[1]*a[2] - b[2]*a[1];
        acc[1] = b[1]*a[3] + a[1]*b[3] + b[2]*a[0] - b[0]*a[2];
        acc[2] = b[2]*a[3] + a[2]*b[3] + b[0]*a[1] - b[1]*a[0];
        acc[3] = b[3]*a[3] - b[0]*a[0] - b[1]*a[1] - b[2]*a[2];
      end
      qau_pkg::FUNC_CONJ: begin
        for (int i = 0; i < 3; i++) acc[i] = -a[i] * Q_UNIT;
        acc[3] = a[3] * Q_UNIT;
      end
      qau_pkg::FUNC_NEG: begin
        for (int i = 0; i < 4; i++) acc[i] = -a[i] * Q_UNIT;
      end
      qau_pkg::FUNC_SCALE: begin
        for (int i = 0; i < 4; i++) acc[i] = a[i] * s;
      end
      qau_pkg::FUNC_DOT: begin
        acc[4] = a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3];
      end
      default: begin
        // lerp, one rounding for the whole expression
        for (int i = 0; i < 4; i++) acc[i] = a[i] * Q_UNIT + (b[i] - a[i]) * s;
      end
    endcase
    for (int i = 0; i < 5; i++) begin
      v = (acc[i] + Q_HALF) >>> FRAC_BITS;
      if (v > V_MAX) begin
        v = V_MAX;
        clipped = 1'b1;
      end else if (v < V_MIN) begin
        v = V_MIN;
        clipped = 1'b1;
      end
      r[i] = comp_t'(v);
    end
    res.rx  = r[0];
    res.ry  = r[1];
    res.rz  = r[2];
    res.rw  = r[3];
    res.so  = r[4];
    res.sat = clipped;
    return res;
  endfunction

  function automatic operand_t mk_op(qau_pkg::func_t f, int ax, int ay, int az, int aw,
                                     int bx, int by, int bz, int bw, int s);
    operand_t op;
    op.func = f;
    op.ax = comp_t'(ax); op.ay = comp_t'(ay); op.az = comp_t'(az); op.aw = comp_t'(aw);
    op.bx = comp_t'(bx); op.by = comp_t'(by); op.bz = comp_t'(bz); op.bw = comp_t'(bw);
    op.s  = comp_t'(s);
    return op;
  endfunction

  // component mix: rails, values between minus one and one that rarely clip, and any value
  function automatic int rand_comp();
    case ($urandom_range(9))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2, 3, 4: return int'($urandom_range(8192)) - 4096;
      default: return int'(comp_t'($urandom));
    endcase
  endfunction

  // lerp and scale amounts lean toward the zero to one span
  function automatic int rand_amount();
    case ($urandom_range(3))
      0, 1:    return int'($urandom_range(32'(Q_UNIT)));
      default: return int'(comp_t'($urandom));
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // operand channel: optional idle cycles, then hold the word until taken
  // valid stays high into the next call, which either drives a new word or
  // drops valid for an idle cycle
  // ------------------------------------------------------------------------
  task automatic send_operands(input operand_t op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= op.func;
    in_if.a_x       <= op.ax;
    in_if.a_y       <= op.ay;
    in_if.a_z       <= op.az;
    in_if.a_w       <= op.aw;
    in_if.b_x       <= op.bx;
    in_if.b_y       <= op.by;
    in_if.b_z       <= op.bz;
    in_if.b_w       <= op.bw;
    in_if.scalar_in <= op.s;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_results.push_back(quat_alu_result(op));
  endtask

  // result channel backpressure, redrawn every cycle
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_field(input string name, input longint exp_v, input longint act_v);
    err_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
  endtask

  // result checker: every word taken is compared with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: result word with nothing expected, got r=(%0d %0d %0d %0d) dot %0d",
                 $time, out_if.r_x, out_if.r_y, out_if.r_z, out_if.r_w, out_if.scalar_out);
      end else begin
        want = pending_results.pop_front();
        if (out_if.r_x !== want.rx) begin
          report_field("r_x", longint'(want.rx), longint'(out_if.r_x));
        end
        if (out_if.r_y !== want.ry) begin
          report_field("r_y", longint'(want.ry), longint'(out_if.r_y));
        end
        if (out_if.r_z !== want.rz) begin
          report_field("r_z", longint'(want.rz), longint'(out_if.r_z));
        end
        if (out_if.r_w !== want.rw) begin
          report_field("r_w", longint'(want.rw), longint'(out_if.r_w));
        end
        if (out_if.scalar_out !== want.so) begin
          report_field("scalar_out", longint'(want.so), longint'(out_if.scalar_out));
        end
        if (out_if.saturated !== want.sat) begin
          report_field("saturated", longint'(want.sat), longint'(out_if.saturated));
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // directed tests
  // ------------------------------------------------------------------------

  // rails on both sides, plus plain sums and differences
  task automatic test_add_sub();
    send_operands(mk_op(qau_pkg::FUNC_ADD, Q_MAX, Q_MAX, Q_MIN, Q_ONE, Q_MAX, 1, Q_MIN, Q_ONE,
                        0));
    send_operands(mk_op(qau_pkg::FUNC_ADD, 100, -200, 300, -400, 5, 6, 7, 8, Q_MAX));
    send_operands(mk_op(qau_pkg::FUNC_SUB, Q_MAX, Q_MIN, 0, Q_ONE, Q_MIN, Q_MAX, Q_MIN, Q_ONE,
                        0));
    send_operands(mk_op(qau_pkg::FUNC_SUB, 1234, -1234, 0, -1, 234, -34, 1, -1, Q_MIN));
  endtask

  // identity, unit axes, the largest magnitudes and an ordinary mix
  task automatic test_product();
    send_operands(mk_op(qau_pkg::FUNC_PROD, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, 0));
    send_operands(mk_op(qau_pkg::FUNC_PROD, Q_ONE, 0, 0, 0, 0, Q_ONE, 0, 0, 0));
    send_operands(mk_op(qau_pkg::FUNC_PROD, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                        Q_MIN, 0));
    send_operands(mk_op(qau_pkg::FUNC_PROD, 1000, -2000, 3000, 500, -700, 800, -900, 1100, 0));
  endtask

  // negating the most negative value clips to the most positive one
  task automatic test_conj_neg();
    send_operands(mk_op(qau_pkg::FUNC_CONJ, Q_MIN, Q_MAX, -1, Q_MIN, 7, -7, Q_MAX, Q_MIN, 5));
    send_operands(mk_op(qau_pkg::FUNC_NEG, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, 0, 0, 0, 0));
    send_operands(mk_op(qau_pkg::FUNC_NEG, Q_MAX, 1, -1, 0, Q_MIN, Q_MIN, 3, 3, -9));
  endtask

  // half-lsb ties go toward plus infinity, zero and minus-one factors
  task automatic test_scale();
    send_operands(mk_op(qau_pkg::FUNC_SCALE, 1, -1, 3, -3, 0, 0, 0, 0, int'(Q_HALF)));
    send_operands(mk_op(qau_pkg::FUNC_SCALE, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1, 2, 3, 4, Q_MIN));
    send_operands(mk_op(qau_pkg::FUNC_SCALE, Q_MAX, Q_MIN, 1000, -1000, Q_MAX, Q_MAX, 0, 0, 0));
    send_operands(mk_op(qau_pkg::FUNC_SCALE, Q_MIN, Q_MAX, 4095, -4096, 0, 0, 0, 0, Q_MONE));
  endtask

  // quaternion fields read zero for dot
  task automatic test_dot();
    send_operands(mk_op(qau_pkg::FUNC_DOT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                        Q_MAX, 0));
    send_operands(mk_op(qau_pkg::FUNC_DOT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX,
                        Q_MAX, 0));
    send_operands(mk_op(qau_pkg::FUNC_DOT, Q_ONE, -2048, 300, 0, 2048, Q_ONE, -77, Q_MIN,
                        Q_MAX));
  endtask

  // ends of the span, midpoint and extrapolation both ways
  task automatic test_lerp();
    send_operands(mk_op(qau_pkg::FUNC_LERP, 100, -100, Q_MAX, Q_MIN, 900, 300, Q_MIN, Q_MAX,
                        0));
    send_operands(mk_op(qau_pkg::FUNC_LERP, 100, -100, Q_MAX, Q_MIN, 900, 300, Q_MIN, Q_MAX,
                        Q_ONE));
    send_operands(mk_op(qau_pkg::FUNC_LERP, 1, -1, 3, 0, 2, -2, 0, 1, int'(Q_HALF)));
    send_operands(mk_op(qau_pkg::FUNC_LERP, Q_MIN, 0, -500, 500, Q_MAX, 10, 500, -500,
                        Q_MAX));
    send_operands(mk_op(qau_pkg::FUNC_LERP, Q_MIN, 0, -500, 500, Q_MAX, 10, 500, -500,
                        Q_MIN));
  endtask

  // random words of every opcode
  task automatic test_random_mix(input int count);
    operand_t op;
    repeat (count) begin
      op = mk_op(qau_pkg::func_t'($urandom_range(7)),
                 rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                 rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                 rand_amount());
      send_operands(op);
    end
  endtask

  // ------------------------------------------------------------------------
  // sequence: reset, directed words, then three random phases with the
  // sender and receiver idling light/heavy, heavy/light and not at all
  // ------------------------------------------------------------------------
  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    err_count       = 0;
    send_idle_pct   = 14;
    recv_idle_pct   = 63;
    in_if.valid     = 1'b0;
    in_if.func      = qau_pkg::FUNC_ADD;
    in_if.a_x       = '0;
    in_if.a_y       = '0;
    in_if.a_z       = '0;
    in_if.a_w       = '0;
    in_if.b_x       = '0;
    in_if.b_y       = '0;
    in_if.b_z       = '0;
    in_if.b_w       = '0;
    in_if.scalar_in = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_add_sub();
    test_product();
    test_conj_neg();
    test_scale();
    test_dot();
    test_lerp();
    test_random_mix(150);

    send_idle_pct = 63;
    recv_idle_pct = 14;
    test_random_mix(150);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(150);
    in_if.valid <= 1'b0;

    // drain, then keep watching for any stray result word
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    if (err_count == 0) begin
      $display("quaternion_arithmetic_unit_tb: done, clean");
    end else begin
      $display("quaternion_arithmetic_unit_tb: done, errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #400000;
    $display("quaternion_arithmetic_unit_tb: done, errors");
    $finish;
  end

endmodule

[files.f]
src/qau_pkg.sv
src/qau_if.sv
src/quaternion_arithmetic_unit.sv
src/qau_checker.sv
bench/quaternion_arithmetic_unit_tb.sv
